>>> rtl/core/sis_pkg.sv
// Package for the stable insertion sorter: payload, command and status types.
// No dependencies; imported by the controller, datapath and top level.
`default_nettype none

package sis_pkg;

  localparam int WEIGHT_BITS = 32;
  localparam int TAG_BITS    = 16;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] item_weight;
    logic [TAG_BITS-1:0]    item_tag;
    logic                   last_item;
  } in_item_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] out_weight;
    logic [TAG_BITS-1:0]    out_tag;
    logic                   out_last;
    logic                   overflow;
  } out_item_t;

  typedef struct packed {
    logic [WEIGHT_BITS-1:0] weight;
    logic [TAG_BITS-1:0]    tag;
  } entry_t;

  typedef struct packed {
    logic accept;
    logic seek;
    logic place;
    logic emit;
  } sis_cmd_t;

  typedef struct packed {
    logic full;
    logic fill_zero;
    logic in_last;
    logic greater;
    logic pos_one;
    logic item_last;
    logic emit_end;
  } sis_status_t;

endpackage

`default_nettype wire

>>> rtl/core/sis_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies; holds the sorter's entry store.
`default_nettype none

module sis_ram #(
  parameter int WIDTH = 48,
  parameter int DEPTH = 64
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata_r
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sis_ctrl.sv
// Sequencing controller for the stable insertion sorter.
// Depends on sis_pkg; drives commands to sis_datapath from its status.
`default_nettype none

module sis_ctrl
  import sis_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire sis_status_t status,
  output sis_cmd_t         cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SEEK,
    ST_PLACE,
    ST_EMIT
  } state_t;

  state_t state_r, state_nxt;

  always_comb begin
    cmd        = '0;
    state_nxt  = state_r;
    case (state_r)
      ST_IDLE: begin
        if (start) begin
          cmd.accept = 1'b1;
          if (status.full || status.fill_zero) begin
            state_nxt = status.in_last ? ST_EMIT : ST_IDLE;
          end else begin
            state_nxt = ST_SEEK;
          end
        end
      end
      ST_SEEK: begin
        cmd.seek = 1'b1;
        if (status.greater) begin
          state_nxt = status.pos_one ? ST_PLACE : ST_SEEK;
        end else begin
          state_nxt = status.item_last ? ST_EMIT : ST_IDLE;
        end
      end
      ST_PLACE: begin
        cmd.place = 1'b1;
        state_nxt = status.item_last ? ST_EMIT : ST_IDLE;
      end
      ST_EMIT: begin
        cmd.emit = 1'b1;
        if (status.emit_end) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  assign busy = (state_r != ST_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/sis_datapath.sv
// Datapath of the stable insertion sorter: entry store, counters, output register.
// Depends on sis_pkg and sis_ram; commanded by sis_ctrl.
`default_nettype none

module sis_datapath
  import sis_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire in_item_t    in_item,
  input  wire sis_cmd_t    cmd,
  output sis_status_t      status,
  output logic             out_valid,
  output out_item_t        out_item
);

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  entry_t          item_r;
  logic            last_r;
  logic [AW-1:0]   pos_r;
  logic [CW-1:0]   fill_r;
  logic            dropped_r;
  logic [AW-1:0]   emit_idx_r;
  logic            out_valid_r;
  logic            out_last_r;
  logic            out_ovf_r;

  logic            we;
  logic [AW-1:0]   waddr;
  entry_t          wdata;
  logic            re;
  logic [AW-1:0]   raddr;
  entry_t          rdata;
  entry_t          in_entry;
  logic            store_in;
  logic            store_item;

  sis_ram #(
    .WIDTH ($bits(entry_t)),
    .DEPTH (MAX_ITEMS)
  ) u_store (
    .clk     (clk),
    .we      (we),
    .waddr   (waddr),
    .wdata   (wdata),
    .re      (re),
    .raddr   (raddr),
    .rdata_r (rdata)
  );

  assign in_entry.weight = in_item.item_weight;
  assign in_entry.tag    = in_item.item_tag;

  assign status.full      = (fill_r == CW'(MAX_ITEMS));
  assign status.fill_zero = (fill_r == '0);
  assign status.in_last   = in_item.last_item;
  assign status.greater   = (rdata.weight > item_r.weight);
  assign status.pos_one   = (pos_r == AW'(1));
  assign status.item_last = last_r;
  assign status.emit_end  = ((CW'(emit_idx_r) + CW'(1)) == fill_r);

  assign store_in   = cmd.accept && !status.full && status.fill_zero;
  assign store_item = (cmd.seek && !status.greater) || cmd.place;

  always_comb begin
    we    = 1'b0;
    waddr = pos_r;
    wdata = item_r;
    re    = 1'b0;
    raddr = emit_idx_r;
    if (store_in) begin
      we    = 1'b1;
      waddr = '0;
      wdata = in_entry;
    end else if (cmd.seek && status.greater) begin
      we    = 1'b1;
      wdata = rdata;
    end else if (store_item) begin
      we    = 1'b1;
    end
    if (cmd.accept && !status.full && !status.fill_zero) begin
      re    = 1'b1;
      raddr = AW'(fill_r - CW'(1));
    end else if (cmd.seek && status.greater && !status.pos_one) begin
      re    = 1'b1;
      raddr = pos_r - AW'(2);
    end else if (cmd.emit) begin
      re    = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      item_r <= in_entry;
      last_r <= in_item.last_item;
      pos_r  <= AW'(fill_r);
    end else if (cmd.seek && status.greater) begin
      pos_r  <= pos_r - AW'(1);
    end
    if (cmd.emit) begin
      out_last_r <= status.emit_end;
      out_ovf_r  <= dropped_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r      <= '0;
      dropped_r   <= 1'b0;
      emit_idx_r  <= '0;
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.emit;
      if (cmd.accept && status.full) begin
        dropped_r <= 1'b1;
      end
      if (store_in || store_item) begin
        fill_r <= fill_r + CW'(1);
      end
      if (cmd.accept) begin
        emit_idx_r <= '0;
      end else if (cmd.emit) begin
        emit_idx_r <= emit_idx_r + AW'(1);
        if (status.emit_end) begin
          fill_r    <= '0;
          dropped_r <= 1'b0;
        end
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_item.out_weight = rdata.weight;
  assign out_item.out_tag    = rdata.tag;
  assign out_item.out_last   = out_last_r;
  assign out_item.overflow   = out_ovf_r;

endmodule

`default_nettype wire

>>> rtl/core/stable_insertion_sorter.sv
// Top level of the stable insertion sorter: controller plus datapath.
// Depends on sis_pkg, sis_ctrl, sis_datapath and sis_ram.
//
// An item is taken when start is high and busy is low. Insertion walks the
// sorted store downwards through one RAM read port, one entry per cycle: an
// item is done as it is taken when the store is empty or full, otherwise it
// walks past each stored entry with a greater weight, at most MAX_ITEMS - 1
// of them. The item flagged last then streams the whole set out, one result
// per cycle on out_valid. Results cannot be held off by the receiver; each
// is valid for one cycle only.
`default_nettype none

module stable_insertion_sorter
  import sis_pkg::*;
#(
  parameter int MAX_ITEMS = 64
) (
  input  wire logic     clk,
  input  wire logic     rst_n,
  input  wire logic     start,
  output logic          busy,
  input  wire in_item_t in_item,
  output logic          out_valid,
  output out_item_t     out_item
);

  sis_cmd_t    cmd;
  sis_status_t status;

  sis_ctrl u_ctrl (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .status (status),
    .cmd    (cmd)
  );

  sis_datapath #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_item   (in_item),
    .cmd       (cmd),
    .status    (status),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

endmodule

`default_nettype wire
